// File: hw/rtl/stktab_pkg.sv
package stktab_pkg;

   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam int unsigned SCORE_STEP = 10;

   typedef struct packed {
      logic load;
      logic find;
      logic update;
   } cmd_type;

endpackage

// File: hw/rtl/sorted_top_k_score_table.sv
// Keeps a table of TABLE_DEPTH score and tag entries sorted by descending signed score; a
// submit inserts below any equal scores and drops the last entry, a read returns one slot.
// Each accepted transfer is latched in the idle state, compared against every slot at
// once in ST_FIND, applied to the table in ST_UPDATE if it is a submit, and its result is
// shown in ST_RESP with rsp_valid high for exactly one cycle. The receiver cannot stall
// that result; busy stays high until it ends, so the next transfer is taken in the cycle after.
module sorted_top_k_score_table
   import stktab_pkg::*;
#(
   parameter int TABLE_DEPTH = 8,
   parameter int TAG_BITS    = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic signed [31:0] req_new_score,
   input  logic        [7:0]  req_new_tag,
   input  logic        [2:0]  req_read_index,
   output logic               rsp_valid,
   output logic               rsp_ranked_in,
   output logic        [2:0]  rsp_position,
   output logic signed [31:0] rsp_slot_score,
   output logic        [7:0]  rsp_slot_tag
);

   cmd_type cmd;

   stktab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   stktab_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_new_score  (req_new_score),
      .req_new_tag    (req_new_tag),
      .req_read_index (req_read_index),
      .rsp_ranked_in  (rsp_ranked_in),
      .rsp_position   (rsp_position),
      .rsp_slot_score (rsp_slot_score),
      .rsp_slot_tag   (rsp_slot_tag)
   );

endmodule

// File: hw/rtl/stktab_ctrl.sv
module stktab_ctrl
   import stktab_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FIND   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.find   = (state_ff == ST_FIND);
   assign cmd.update = (state_ff == ST_UPDATE);

   a_accept_to_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted transfer did not produce a result three cycles later");

   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after the result transfer");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.find, cmd.update}))
      else $error("more than one datapath command at once");

endmodule

// File: hw/rtl/stktab_dpath.sv
module stktab_dpath
   import stktab_pkg::*;
#(
   parameter int TABLE_DEPTH = 8,
   parameter int TAG_BITS    = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               req_kind,
   input  logic signed [31:0] req_new_score,
   input  logic        [7:0]  req_new_tag,
   input  logic        [2:0]  req_read_index,
   output logic               rsp_ranked_in,
   output logic        [2:0]  rsp_position,
   output logic signed [31:0] rsp_slot_score,
   output logic        [7:0]  rsp_slot_tag
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic signed [31:0]         score_slots_ff [TABLE_DEPTH];
   logic        [TAG_BITS-1:0] tag_slots_ff   [TABLE_DEPTH];

   logic                       kind_ff;
   logic signed [31:0]         score_ff;
   logic        [TAG_BITS-1:0] tag_ff;
   logic        [2:0]          rd_ff;

   logic [TABLE_DEPTH-1:0] less_ff;
   logic [TABLE_DEPTH-1:0] less_in;
   logic [TABLE_DEPTH-1:0] first;

   logic                  hit;
   logic [IDX_W-1:0]      ins_pos;
   logic                  rd_in_range;
   logic [IDX_W-1:0]      rd_sel;

   logic                  ranked_ff;
   logic [2:0]            pos_ff;
   logic signed [31:0]    rscore_ff;
   logic [7:0]            rtag_ff;
   logic                  ranked_in;
   logic [2:0]            pos_in;
   logic signed [31:0]    rscore_in;
   logic [7:0]            rtag_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         score_ff <= req_new_score;
         tag_ff   <= TAG_BITS'(req_new_tag);
         rd_ff    <= req_read_index;
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         less_in[i] = (score_slots_ff[i] < score_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.find) begin
         less_ff <= less_in;
      end
   end

   // The table stays sorted, so the compare flags form a thermometer code.
   always_comb begin
      first   = less_ff & ~(less_ff << 1);
      ins_pos = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (first[i]) begin
            ins_pos = ins_pos | IDX_W'(i);
         end
      end
      hit = |less_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            score_slots_ff[i] <= 32'((TABLE_DEPTH - i) * SCORE_STEP);
            tag_slots_ff[i]   <= '0;
         end
      end else if (cmd.update && (kind_ff == KIND_SUBMIT)) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (first[i]) begin
               score_slots_ff[i] <= score_ff;
               tag_slots_ff[i]   <= tag_ff;
            end else if (less_ff[i] && (i > 0)) begin
               score_slots_ff[i] <= score_slots_ff[(i > 0) ? i - 1 : 0];
               tag_slots_ff[i]   <= tag_slots_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   assign rd_sel      = IDX_W'(rd_ff);
   assign rd_in_range = (32'(rd_ff) < 32'(TABLE_DEPTH));

   always_comb begin
      ranked_in = 1'b0;
      pos_in    = '0;
      rscore_in = '0;
      rtag_in   = '0;
      if (kind_ff == KIND_READ) begin
         pos_in = rd_ff;
         if (rd_in_range) begin
            rscore_in = score_slots_ff[rd_sel];
            rtag_in   = 8'(tag_slots_ff[rd_sel]);
         end
      end else if (hit) begin
         ranked_in = 1'b1;
         pos_in    = 3'(ins_pos);
         rscore_in = score_ff;
         rtag_in   = 8'(tag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ranked_ff <= ranked_in;
         pos_ff    <= pos_in;
         rscore_ff <= rscore_in;
         rtag_ff   <= rtag_in;
      end
   end

   assign rsp_ranked_in  = ranked_ff;
   assign rsp_position   = pos_ff;
   assign rsp_slot_score = rscore_ff;
   assign rsp_slot_tag   = rtag_ff;

endmodule
